[rtl/sdcp_pkg.sv]
// Shared types and character constants of the serial duty command parser.
package sdcp_pkg;

    // Received characters with a meaning to the parser.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_G      = 8'h67;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_W      = 8'h77;

    // Event kinds.
    localparam logic [1:0] KIND_DUTY    = 2'd0;
    localparam logic [1:0] KIND_VERSION = 2'd1;
    localparam logic [1:0] KIND_FLUSH   = 2'd2;

    // Channels.
    localparam logic [1:0] CHAN_RED   = 2'd0;
    localparam logic [1:0] CHAN_GREEN = 2'd1;
    localparam logic [1:0] CHAN_BLUE  = 2'd2;
    localparam logic [1:0] CHAN_WHITE = 2'd3;

    // Number reader phases.
    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    localparam int NUM_RES = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] chan;
        logic [9:0] duty;
    } t_result;

    typedef struct packed {
        logic [2:0]                 count;
        t_result [NUM_RES-1:0]      res;
    } t_batch;

endpackage

[rtl/sdcp_parser.sv]
// Command state of the parser and the decode of one character into a result batch.
module sdcp_parser #(
    parameter int LAST_POSITION = 30,
    parameter int DUTY_MAX      = 1023,
    parameter int LIST_SLOTS    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  logic [7:0]       i_char,
    output sdcp_pkg::t_batch o_batch
);

    localparam int WPW        = $clog2(LAST_POSITION + 1);
    localparam int MW         = $clog2(DUTY_MAX + 2);
    localparam int PW         = MW + 4;
    localparam int EW         = (MW > 10) ? MW : 10;
    localparam int LCW        = $clog2(LIST_SLOTS + 1);
    localparam int LIST_DEPTH = (LIST_SLOTS > 4) ? LIST_SLOTS : 4;

    localparam logic [MW-1:0] DUTY_MAX_M = MW'(DUTY_MAX);
    localparam logic [MW-1:0] DUTY_SAT_M = MW'(DUTY_MAX + 1);
    localparam logic [PW-1:0] DUTY_MAX_P = PW'(DUTY_MAX);
    localparam logic [WPW-1:0] LAST_POS_W = WPW'(LAST_POSITION);

    logic [WPW-1:0] r_wpos,    n_wpos;
    logic [7:0]     r_letter,  n_letter;
    logic           r_seen,    n_seen;
    logic [1:0]     r_phase,   n_phase;
    logic           r_minus,   n_minus;
    logic [MW-1:0]  r_mag,     n_mag;
    logic           r_tok,     n_tok;
    logic [9:0]     r_list [LIST_DEPTH];
    logic [9:0]     n_list [LIST_DEPTH];
    logic [LCW-1:0] r_lcnt,    n_lcnt;

    // Number reader outcome for the current character.
    logic           is_ws;
    logic           is_digit;
    logic [PW-1:0]  prod;
    logic [1:0]     fd_phase;
    logic           fd_minus;
    logic [MW-1:0]  fd_mag;
    logic [9:0]     commit_v;
    logic [9:0]     single_v;
    logic [EW-1:0]  ext_v;
    logic [EW-1:0]  ext_c;
    logic [MW-1:0]  clamp_m;
    logic [9:0]     list_out [sdcp_pkg::NUM_RES];
    logic           dropped;

    always_comb begin
        is_ws    = (i_char == sdcp_pkg::CH_SPACE) ||
                   ((i_char >= sdcp_pkg::CH_TAB) && (i_char <= sdcp_pkg::CH_CR));
        is_digit = (i_char >= sdcp_pkg::CH_ZERO) && (i_char <= sdcp_pkg::CH_NINE);
        // Multiply by ten as shifts and add.
        prod     = (PW'(r_mag) << 3) + (PW'(r_mag) << 1) + PW'(i_char[3:0]);
        fd_phase = r_phase;
        fd_minus = r_minus;
        fd_mag   = r_mag;
        priority if (r_phase == sdcp_pkg::PH_SKIP && is_ws) begin
            fd_phase = r_phase;
        end else if (r_phase == sdcp_pkg::PH_SKIP &&
                     (i_char == sdcp_pkg::CH_PLUS || i_char == sdcp_pkg::CH_MINUS)) begin
            fd_minus = (i_char == sdcp_pkg::CH_MINUS);
            fd_phase = sdcp_pkg::PH_SIGN;
        end else if (r_phase != sdcp_pkg::PH_DONE && is_digit) begin
            fd_phase = sdcp_pkg::PH_DIGITS;
            fd_mag   = (prod > DUTY_MAX_P) ? DUTY_SAT_M : prod[MW-1:0];
        end else begin
            fd_phase = sdcp_pkg::PH_DONE;
        end

        // A list token out of range, or negative, counts as zero.
        ext_c    = EW'(r_mag);
        commit_v = (r_minus || r_mag > DUTY_MAX_M) ? 10'd0 : ext_c[9:0];
        clamp_m  = r_minus ? '0 : ((r_mag > DUTY_MAX_M) ? DUTY_MAX_M : r_mag);
        ext_v    = EW'(clamp_m);
        single_v = ext_v[9:0];

        // List values as seen at the terminator, with a pending token committed.
        for (int k = 0; k < sdcp_pkg::NUM_RES; k++) begin
            list_out[k] = r_list[k];
            if (r_tok && int'(r_lcnt) == k && k < LIST_SLOTS) begin
                list_out[k] = commit_v;
            end
        end
    end

    always_comb begin
        n_wpos   = r_wpos;
        n_letter = r_letter;
        n_seen   = r_seen;
        n_phase  = r_phase;
        n_minus  = r_minus;
        n_mag    = r_mag;
        n_tok    = r_tok;
        n_lcnt   = r_lcnt;
        for (int k = 0; k < LIST_DEPTH; k++) begin
            n_list[k] = r_list[k];
        end
        o_batch  = '0;
        dropped  = (i_char == sdcp_pkg::CH_LF) || (i_char == sdcp_pkg::CH_CR) ||
                   (i_char == sdcp_pkg::CH_NUL);

        if (i_go && !dropped) begin
            n_wpos = r_wpos + 1'b1;
            if (r_wpos >= LAST_POS_W || i_char == sdcp_pkg::CH_DOLLAR) begin
                if (r_wpos < LAST_POS_W && r_seen) begin
                    unique case (r_letter)
                        sdcp_pkg::CH_A: begin
                            o_batch.count = 3'd4;
                            for (int k = 0; k < sdcp_pkg::NUM_RES; k++) begin
                                o_batch.res[k].kind = sdcp_pkg::KIND_DUTY;
                                o_batch.res[k].chan = 2'(k);
                                o_batch.res[k].duty = list_out[k];
                            end
                        end
                        sdcp_pkg::CH_R, sdcp_pkg::CH_G, sdcp_pkg::CH_B, sdcp_pkg::CH_W: begin
                            o_batch.count       = 3'd1;
                            o_batch.res[0].kind = sdcp_pkg::KIND_DUTY;
                            o_batch.res[0].duty = single_v;
                            unique case (r_letter)
                                sdcp_pkg::CH_R: o_batch.res[0].chan = sdcp_pkg::CHAN_RED;
                                sdcp_pkg::CH_G: o_batch.res[0].chan = sdcp_pkg::CHAN_GREEN;
                                sdcp_pkg::CH_B: o_batch.res[0].chan = sdcp_pkg::CHAN_BLUE;
                                default:        o_batch.res[0].chan = sdcp_pkg::CHAN_WHITE;
                            endcase
                        end
                        sdcp_pkg::CH_V: begin
                            o_batch.count       = 3'd1;
                            o_batch.res[0].kind = sdcp_pkg::KIND_VERSION;
                        end
                        sdcp_pkg::CH_F: begin
                            o_batch.count       = 3'd1;
                            o_batch.res[0].kind = sdcp_pkg::KIND_FLUSH;
                        end
                        default: begin
                            o_batch.count = 3'd0;
                        end
                    endcase
                end
                // Both a terminator and an overlong command restart collection.
                n_wpos   = '0;
                n_letter = '0;
                n_seen   = 1'b0;
                n_tok    = 1'b0;
                n_lcnt   = '0;
                n_phase  = sdcp_pkg::PH_SKIP;
                n_minus  = 1'b0;
                n_mag    = '0;
                for (int k = 0; k < LIST_DEPTH; k++) begin
                    n_list[k] = '0;
                end
            end else if (!r_seen) begin
                n_letter = i_char;
                n_seen   = 1'b1;
            end else if (r_letter == sdcp_pkg::CH_A && i_char == sdcp_pkg::CH_COMMA) begin
                if (r_tok) begin
                    for (int k = 0; k < LIST_DEPTH; k++) begin
                        if (int'(r_lcnt) == k && k < LIST_SLOTS) begin
                            n_list[k] = commit_v;
                        end
                    end
                    if (int'(r_lcnt) < LIST_SLOTS) begin
                        n_lcnt = r_lcnt + 1'b1;
                    end
                    n_tok   = 1'b0;
                    n_phase = sdcp_pkg::PH_SKIP;
                    n_minus = 1'b0;
                    n_mag   = '0;
                end
            end else begin
                if (r_letter == sdcp_pkg::CH_A) begin
                    n_tok = 1'b1;
                end
                n_phase = fd_phase;
                n_minus = fd_minus;
                n_mag   = fd_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos   <= '0;
            r_letter <= '0;
            r_seen   <= 1'b0;
            r_phase  <= sdcp_pkg::PH_SKIP;
            r_minus  <= 1'b0;
            r_mag    <= '0;
            r_tok    <= 1'b0;
            r_lcnt   <= '0;
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_list[k] <= '0;
            end
        end else begin
            r_wpos   <= n_wpos;
            r_letter <= n_letter;
            r_seen   <= n_seen;
            r_phase  <= n_phase;
            r_minus  <= n_minus;
            r_mag    <= n_mag;
            r_tok    <= n_tok;
            r_lcnt   <= n_lcnt;
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_list[k] <= n_list[k];
            end
        end
    end

endmodule

[rtl/serial_duty_command_parser_core.sv]
// Top level of the serial duty command parser: input register, parser and result batch.
//
// Characters enter on the rx channel (i_rx_valid, o_rx_ready, i_rx_char), one per
// transfer. Results leave on the res channel (o_res_valid, i_res_ready) with event
// kind, channel, duty and a last flag on the final result caused by a character.
// A transfer lands in an input register; once the batch register is free, the parser
// updates its command state and loads any results into a batch register of up to four
// entries, from which the first result is offered. Characters that cause no result
// are taken at one per cycle while no batch is draining. The batch register drains
// one result per cycle while the receiver is ready, so a '$' that ends an 'a' command
// holds the parser until all four results are taken; that drain sets the rate.
// A stalled receiver keeps the batch in place; the input register then fills
// and o_rx_ready drops until the last result of the batch is taken.
// Reset (synchronous, active low) empties both registers and clears the command
// state; no clearing pass follows, so a character may be sent in the next cycle.
module serial_duty_command_parser_core #(
    parameter int LAST_POSITION = 30,
    parameter int DUTY_MAX      = 1023,
    parameter int LIST_SLOTS    = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_char,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output logic [1:0] o_event_kind,
    output logic [1:0] o_channel,
    output logic [9:0] o_duty,
    output logic       o_last
);

    logic                                   r_in_vld;
    logic [7:0]                             r_in_char;
    logic                                   r_b_vld;
    logic [1:0]                             r_b_idx;
    logic [1:0]                             r_b_last;
    sdcp_pkg::t_result [sdcp_pkg::NUM_RES-1:0] r_b_res;

    sdcp_pkg::t_batch batch;
    logic             out_fire;
    logic             batch_free;
    logic             proc_go;
    logic             load;

    assign out_fire   = o_res_valid && i_res_ready;
    assign batch_free = !r_b_vld || (out_fire && o_last);
    assign proc_go    = r_in_vld && batch_free;
    assign load       = proc_go && (batch.count != 3'd0);
    assign o_rx_ready = !r_in_vld || proc_go;

    sdcp_parser #(
        .LAST_POSITION (LAST_POSITION),
        .DUTY_MAX      (DUTY_MAX),
        .LIST_SLOTS    (LIST_SLOTS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (proc_go),
        .i_char  (r_in_char),
        .o_batch (batch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_rx_ready) begin
            r_in_vld <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_in_char <= i_rx_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_b_idx <= '0;
        end else if (load) begin
            r_b_vld <= 1'b1;
            r_b_idx <= '0;
        end else if (out_fire) begin
            if (o_last) begin
                r_b_vld <= 1'b0;
            end else begin
                r_b_idx <= r_b_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b_last <= 2'(batch.count - 3'd1);
            r_b_res  <= batch.res;
        end
    end

    assign o_res_valid  = r_b_vld;
    assign o_event_kind = r_b_res[r_b_idx].kind;
    assign o_channel    = r_b_res[r_b_idx].chan;
    assign o_duty       = r_b_res[r_b_idx].duty;
    assign o_last       = (r_b_idx == r_b_last);

    // The drain index never runs past the last entry of the batch.
    a_idx_in_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_vld |-> (r_b_idx <= r_b_last))
        else $error("batch index beyond last entry");

    // A loaded batch starts from its first entry.
    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_b_vld && r_b_idx == 2'd0))
        else $error("batch not started at first entry");

    // A character blocked by a busy batch stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !proc_go) |=> (r_in_vld && $stable(r_in_char)))
        else $error("blocked character lost");

    // Requests carry no channel or duty and are single results.
    a_request_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_event_kind != sdcp_pkg::KIND_DUTY)
            |-> (o_channel == 2'd0 && o_duty == 10'd0 && o_last))
        else $error("malformed request result");

endmodule

[tb/duty_event_checker.sv]
// Watches both channels of the duty command parser, predicts its events and compares them.
module duty_event_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    input  logic       i_rx_ready,
    input  logic [7:0] i_rx_char,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [1:0] i_event_kind,
    input  logic [1:0] i_channel,
    input  logic [9:0] i_duty,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_events_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_POSITION = 30;
    localparam int DUTY_MAX      = 1023;
    localparam int LIST_SLOTS    = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] chan;
        logic [9:0] duty;
        logic       last;
    } t_duty_event;

    t_duty_event events_q[$];
    int          fail_count = 0;
    int          events_due = 0;

    // Parser state as the block should hold it.
    int unsigned chars_held;
    logic [7:0]  cmd_letter;
    bit          have_letter;
    logic [1:0]  num_phase;
    bit          negative;
    int unsigned mag;
    bit          token_busy;
    int unsigned slot_val[LIST_SLOTS];
    int unsigned slots_used;

    assign o_fail_count = fail_count;
    assign o_events_due = events_due;

    function void clear_number();
        num_phase = sdcp_pkg::PH_SKIP;
        negative  = 1'b0;
        mag       = 0;
    endfunction

    function void clear_command();
        chars_held  = 0;
        cmd_letter  = sdcp_pkg::CH_NUL;
        have_letter = 1'b0;
        token_busy  = 1'b0;
        slots_used  = 0;
        for (int k = 0; k < LIST_SLOTS; k++) slot_val[k] = 0;
        clear_number();
    endfunction

    function void take_number_char(input logic [7:0] c);
        if (num_phase == sdcp_pkg::PH_SKIP) begin
            if (c == sdcp_pkg::CH_SPACE ||
                (c >= sdcp_pkg::CH_TAB && c <= sdcp_pkg::CH_CR)) return;
            if (c == sdcp_pkg::CH_PLUS || c == sdcp_pkg::CH_MINUS) begin
                negative  = (c == sdcp_pkg::CH_MINUS);
                num_phase = sdcp_pkg::PH_SIGN;
                return;
            end
        end
        if (num_phase != sdcp_pkg::PH_DONE &&
            c >= sdcp_pkg::CH_ZERO && c <= sdcp_pkg::CH_NINE) begin
            num_phase = sdcp_pkg::PH_DIGITS;
            mag = mag * 10 + 32'(c - sdcp_pkg::CH_ZERO);
            // The magnitude saturates just above the largest duty value.
            if (mag > DUTY_MAX) mag = DUTY_MAX + 1;
            return;
        end
        num_phase = sdcp_pkg::PH_DONE;
    endfunction

    function void close_token();
        int unsigned v;
        v = (negative || mag > DUTY_MAX) ? 0 : mag;
        if (slots_used < LIST_SLOTS) begin
            slot_val[slots_used] = v;
            slots_used++;
        end
        token_busy = 1'b0;
        clear_number();
    endfunction

    function void push_event(input logic [1:0] kind, input logic [1:0] chan,
                             input int unsigned duty, input bit last);
        t_duty_event ev;
        ev.kind = kind;
        ev.chan = chan;
        ev.duty = duty[9:0];
        ev.last = last;
        events_q.push_back(ev);
    endfunction

    function void run_command();
        int unsigned v;
        logic [1:0]  ch;
        if (!have_letter) return;
        case (cmd_letter)
            sdcp_pkg::CH_A: begin
                if (token_busy) close_token();
                for (int k = 0; k < 4; k++) begin
                    v = (k < LIST_SLOTS) ? slot_val[k] : 0;
                    push_event(sdcp_pkg::KIND_DUTY, k[1:0], v, k == 3);
                end
            end
            sdcp_pkg::CH_R, sdcp_pkg::CH_G, sdcp_pkg::CH_B, sdcp_pkg::CH_W: begin
                v = negative ? 0 : mag;
                if (v > DUTY_MAX) v = DUTY_MAX;
                ch = (cmd_letter == sdcp_pkg::CH_R) ? sdcp_pkg::CHAN_RED :
                     (cmd_letter == sdcp_pkg::CH_G) ? sdcp_pkg::CHAN_GREEN :
                     (cmd_letter == sdcp_pkg::CH_B) ? sdcp_pkg::CHAN_BLUE :
                                                      sdcp_pkg::CHAN_WHITE;
                push_event(sdcp_pkg::KIND_DUTY, ch, v, 1'b1);
            end
            sdcp_pkg::CH_V: push_event(sdcp_pkg::KIND_VERSION, '0, 0, 1'b1);
            sdcp_pkg::CH_F: push_event(sdcp_pkg::KIND_FLUSH, '0, 0, 1'b1);
            default: ;
        endcase
    endfunction

    function void parse_char(input logic [7:0] c);
        if (c == sdcp_pkg::CH_LF || c == sdcp_pkg::CH_CR || c == sdcp_pkg::CH_NUL) return;
        // The character past the last position is thrown away, even a terminator.
        if (chars_held >= LAST_POSITION) begin
            clear_command();
            return;
        end
        chars_held++;
        if (c == sdcp_pkg::CH_DOLLAR) begin
            run_command();
            clear_command();
            return;
        end
        if (!have_letter) begin
            cmd_letter  = c;
            have_letter = 1'b1;
            return;
        end
        if (cmd_letter == sdcp_pkg::CH_A) begin
            if (c == sdcp_pkg::CH_COMMA) begin
                if (token_busy) close_token();
                return;
            end
            token_busy = 1'b1;
        end
        take_number_char(c);
    endfunction

    function void check_field(input string what, input int unsigned want_v,
                              input int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
            fail_count++;
        end
    endfunction

    initial clear_command();

    always @(posedge i_clk) begin : watch
        t_duty_event want;
        if (!i_rst_n) begin
            clear_command();
            events_q.delete();
        end else begin
            if (i_rx_valid && i_rx_ready) parse_char(i_rx_char);
            if (i_res_valid && i_res_ready) begin
                if (events_q.size() == 0) begin
                    $display("%0t: expected no result, got kind %0d chan %0d duty %0d last %0d",
                             $time, i_event_kind, i_channel, i_duty, i_last);
                    fail_count++;
                end else begin
                    want = events_q.pop_front();
                    check_field("event_kind", 32'(want.kind), 32'(i_event_kind));
                    check_field("channel", 32'(want.chan), 32'(i_channel));
                    check_field("duty", 32'(want.duty), 32'(i_duty));
                    check_field("last", 32'(want.last), 32'(i_last));
                end
            end
        end
        events_due = events_q.size();
    end

endmodule

[tb/tb.sv]
// Top of the duty command parser testbench: clock, reset, character stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_CHARS = 340;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int DRAIN_CYCLES = 20;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_rx_valid;
    logic       o_rx_ready;
    logic [7:0] i_rx_char;
    logic       o_res_valid;
    logic       i_res_ready;
    logic [1:0] o_event_kind;
    logic [1:0] o_channel;
    logic [9:0] o_duty;
    logic       o_last;
    int         fail_count;
    int         events_due;

    logic [7:0] tx_chars[$];
    int         rx_sent = 0;
    logic [7:0] chan_letters[4] = '{sdcp_pkg::CH_R, sdcp_pkg::CH_G,
                                    sdcp_pkg::CH_B, sdcp_pkg::CH_W};

    serial_duty_command_parser_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .o_rx_ready   (o_rx_ready),
        .i_rx_char    (i_rx_char),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_event_kind (o_event_kind),
        .o_channel    (o_channel),
        .o_duty       (o_duty),
        .o_last       (o_last)
    );

    duty_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_rx_valid),
        .i_rx_ready   (o_rx_ready),
        .i_rx_char    (i_rx_char),
        .i_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .i_event_kind (o_event_kind),
        .i_channel    (o_channel),
        .i_duty       (o_duty),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_events_due (events_due)
    );

    always #6 i_clk = ~i_clk;

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function void push_text(input string s);
        for (int i = 0; i < s.len(); i++) tx_chars.push_back(s[i]);
    endfunction

    // Now and then a dropped byte slips in ahead of a character.
    function void push_noisy(input logic [7:0] c);
        int r;
        if ($urandom_range(0, 39) == 0) begin
            r = $urandom_range(0, 2);
            tx_chars.push_back(r == 0 ? sdcp_pkg::CH_LF :
                               (r == 1 ? sdcp_pkg::CH_CR : sdcp_pkg::CH_NUL));
        end
        tx_chars.push_back(c);
    endfunction

    function void push_text_noisy(input string s);
        for (int i = 0; i < s.len(); i++) push_noisy(s[i]);
    endfunction

    function void add_number();
        int r;
        int v;
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2))
                push_noisy($urandom_range(0, 5) == 0 ? sdcp_pkg::CH_SPACE :
                                                       8'($urandom_range(9, 13)));
        end
        r = $urandom_range(0, 7);
        if (r == 0) push_noisy(sdcp_pkg::CH_MINUS);
        else if (r == 1) push_noisy(sdcp_pkg::CH_PLUS);
        r = $urandom_range(0, 9);
        case (r)
            0:       v = -1;
            1:       v = $urandom_range(0, 9);
            2, 3:    v = $urandom_range(10, 99);
            4, 5:    v = $urandom_range(100, 1019);
            6, 7:    v = $urandom_range(1020, 1030);
            default: v = $urandom_range(1031, 99999);
        endcase
        if (v >= 0) begin
            if ($urandom_range(0, 9) == 0) push_noisy(sdcp_pkg::CH_ZERO);
            push_text_noisy($sformatf("%0d", v));
        end
        if ($urandom_range(0, 5) == 0)
            push_noisy($urandom_range(0, 1) ? sdcp_pkg::CH_SPACE :
                                              8'($urandom_range(33, 126)));
    endfunction

    // Mostly well-formed commands with random content, the rest broken or noise.
    function void add_random_command();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            push_noisy(chan_letters[$urandom_range(0, 3)]);
            add_number();
            if ($urandom_range(0, 3) == 0) push_noisy(8'($urandom_range(33, 126)));
            push_noisy(sdcp_pkg::CH_DOLLAR);
        end else if (pick < 65) begin
            push_noisy(sdcp_pkg::CH_A);
            n = $urandom_range(0, 6);
            for (int k = 0; k < n; k++) begin
                if (k > 0) push_noisy(sdcp_pkg::CH_COMMA);
                if ($urandom_range(0, 5) != 0) add_number();
                if ($urandom_range(0, 7) == 0) push_noisy(sdcp_pkg::CH_COMMA);
            end
            push_noisy(sdcp_pkg::CH_DOLLAR);
        end else if (pick < 75) begin
            push_noisy($urandom_range(0, 1) ? sdcp_pkg::CH_V : sdcp_pkg::CH_F);
            push_noisy(sdcp_pkg::CH_DOLLAR);
        end else if (pick < 80) begin
            if ($urandom_range(0, 1)) push_noisy(8'($urandom_range(1, 255)));
            push_noisy(sdcp_pkg::CH_DOLLAR);
        end else if (pick < 85) begin
            push_noisy(chan_letters[$urandom_range(0, 3)]);
            repeat ($urandom_range(27, 32))
                push_noisy(8'($urandom_range(sdcp_pkg::CH_ZERO, sdcp_pkg::CH_NINE)));
            push_noisy(sdcp_pkg::CH_DOLLAR);
        end else begin
            repeat ($urandom_range(1, 6)) push_noisy(8'($urandom_range(0, 255)));
        end
    endfunction

    function void build_stimulus();
        int directed_len;
        tx_chars.push_back(sdcp_pkg::CH_LF);
        tx_chars.push_back(sdcp_pkg::CH_CR);
        tx_chars.push_back(sdcp_pkg::CH_NUL);
        push_text("v$f$$x7$");
        tx_chars.push_back(8'hFF);
        push_text("$r \t2000$g-5$b+12x9$w$r1023$g1024$");
        push_text("a1,,-3,2000,7,9$a$a 5 , +6$");
        // A command of exactly the last position is run; one character more is lost.
        push_text("w");
        repeat (28) push_text("1");
        push_text("$");
        push_text("r");
        repeat (29) push_text("9");
        push_text("$b3$");
        directed_len = tx_chars.size();
        while (tx_chars.size() < directed_len + RANDOM_CHARS) add_random_command();
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : sink
        int  left;
        bit  level;
        bit  held;
        left  = 0;
        level = 1'b0;
        held  = 1'b0;
        i_res_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && rx_sent >= HOLD_AFTER) begin
                // Long hold-off so the block fills up and stops taking characters.
                held  = 1'b1;
                level = 1'b0;
                left  = HOLD_CYCLES;
            end else if (left == 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    level = 1'b1;
                    left  = $urandom_range(1, 24);
                end else begin
                    level = 1'b0;
                    left  = pick_gap() + 1;
                end
            end
            i_res_ready <= level;
            left--;
        end
    end

    initial begin : source
        logic [7:0] c;
        int         gap;
        int         burst_left;
        burst_left = 0;
        i_rx_valid <= 1'b0;
        i_rx_char  <= '0;
        build_stimulus();
        do @(posedge i_clk); while (!i_rst_n);
        while (tx_chars.size() > 0) begin
            c = tx_chars.pop_front();
            i_rx_valid <= 1'b1;
            i_rx_char  <= c;
            do @(posedge i_clk); while (!o_rx_ready);
            rx_sent++;
            if (burst_left > 0) begin
                burst_left--;
                gap = 0;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(16, 40);
            end
            if (gap > 0 || tx_chars.size() == 0) begin
                i_rx_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        @(posedge i_clk);
        while (events_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && events_due == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
